### sv/efp_pkg.sv
// Package for the encoder frame parser: widths, character codes, phase
// encodings and the helpers that turn a parsed magnitude into an output field.
// No dependencies.
package efp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;

  localparam logic [7:0] CH_START = 8'h3F;  // '?'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'b0001,
    PH_RIGHT = 4'b0010,
    PH_LEFT  = 4'b0100,
    PH_TIME  = 4'b1000
  } frame_phase_t;

  typedef enum logic [2:0] {
    NUM_SKIP   = 3'b001,
    NUM_DIGITS = 3'b010,
    NUM_DONE   = 3'b100
  } num_phase_t;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // Two's complement value of a field from its sign and magnitude.
  function automatic value_t field_value(input logic negative, input value_t mag);
    value_t v;
    v = negative ? value_t'(-mag) : mag;
    return v;
  endfunction

  // Low OUT_WIDTH bits of the sign-extended value.
  function automatic logic signed [OUT_WIDTH-1:0] to_field(input value_t v);
    logic signed [63:0] wide;
    wide = 64'(signed'(v));
    return wide[OUT_WIDTH-1:0];
  endfunction

endpackage

### sv/efp_if.sv
// Channel interfaces of the encoder frame parser: the byte request channel
// and the frame result channel. Depends on efp_pkg.
interface efp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface efp_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [efp_pkg::OUT_WIDTH-1:0] left_ticks;
  logic signed [efp_pkg::OUT_WIDTH-1:0] right_ticks;
  logic signed [efp_pkg::OUT_WIDTH-1:0] elapsed_time;
  logic signed [efp_pkg::OUT_WIDTH-1:0] prev_left_ticks;
  logic signed [efp_pkg::OUT_WIDTH-1:0] prev_right_ticks;
  logic signed [efp_pkg::OUT_WIDTH-1:0] prev_elapsed_time;
  logic                                  saturated;

  modport source (output valid, output left_ticks, output right_ticks,
                  output elapsed_time, output prev_left_ticks,
                  output prev_right_ticks, output prev_elapsed_time,
                  output saturated, input ready);
  modport sink (input valid, input left_ticks, input right_ticks,
                input elapsed_time, input prev_left_ticks,
                input prev_right_ticks, input prev_elapsed_time,
                input saturated, output ready);
endinterface

### sv/encoder_frame_parser_top.sv
// Top level of the encoder frame parser: byte input register, frame and
// number state, and the result register. Depends on efp_pkg, efp_if.sv and
// efp_digit_step.
//
// Usage: bytes of a serial stream enter on rx, one request per byte. The
// block hunts for '?', then reads the right count up to ',', the left count
// up to ':' and the time up to ';'. Each field follows atoi rules (leading
// whitespace, optional sign, decimal digits) and saturates to 32-bit signed,
// which raises the saturated flag. The ';' that closes a frame produces one
// request on res with the three new values and the three of the frame
// before; every other byte produces nothing.
// Throughput is one byte per cycle while no closing ';' waits on a stalled
// res. A byte is registered in the input register at acceptance and parsed
// from there; a parsed closing ';' loads the result register and sets res.valid.
// Reset clears the phases, the held and previous values, and both valid
// flags; previous values read as zero before the first frame.
// When res stalls, a finished result waits in its register while bytes that
// do not close a frame keep flowing; only a second ';' waits in the input
// register, and rx.ready drops once that register is full.
module encoder_frame_parser_top (
  input logic               clk,
  input logic               rst,
  efp_byte_if.sink          rx,
  efp_result_if.source      res
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Parser state.
  efp_pkg::frame_phase_t frame_phase, frame_phase_next;
  efp_pkg::num_phase_t   num_phase, num_phase_next;
  logic                  negative_sign, negative_sign_next;
  efp_pkg::value_t       accumulator, accumulator_next;
  efp_pkg::value_t       held_right, held_right_next;
  efp_pkg::value_t       held_left, held_left_next;
  logic                  overflow_seen, overflow_seen_next;
  efp_pkg::value_t       latest_left, latest_left_next;
  efp_pkg::value_t       latest_right, latest_right_next;
  efp_pkg::value_t       latest_time, latest_time_next;

  logic            emit;
  logic            feed;
  logic            take_digit;
  logic            is_digit;
  logic            is_space;
  logic            advance;
  efp_pkg::value_t cur_value;
  efp_pkg::value_t step_acc;
  logic            step_ovf;

  efp_digit_step u_digit (
    .acc      (accumulator),
    .negative (negative_sign),
    .digit    (s1_byte[3:0]),
    .acc_next (step_acc),
    .overflow (step_ovf)
  );

  assign is_digit  = (s1_byte >= efp_pkg::CH_ZERO) && (s1_byte <= efp_pkg::CH_NINE);
  assign is_space  = (s1_byte == efp_pkg::CH_SPACE) ||
                     ((s1_byte >= efp_pkg::CH_TAB) && (s1_byte <= efp_pkg::CH_CR));
  assign cur_value = efp_pkg::field_value(negative_sign, accumulator);

  // A byte that closes a frame may only be parsed when the result register
  // can take its result.
  assign advance  = s1_valid && !(emit && res.valid && !res.ready);
  assign rx.ready = !s1_valid || advance;

  always_comb begin
    frame_phase_next   = frame_phase;
    num_phase_next     = num_phase;
    negative_sign_next = negative_sign;
    accumulator_next   = accumulator;
    held_right_next    = held_right;
    held_left_next     = held_left;
    overflow_seen_next = overflow_seen;
    latest_left_next   = latest_left;
    latest_right_next  = latest_right;
    latest_time_next   = latest_time;
    emit               = 1'b0;
    feed               = 1'b0;
    take_digit         = 1'b0;

    unique case (frame_phase)
      efp_pkg::PH_HUNT: begin
        if (s1_byte == efp_pkg::CH_START) begin
          frame_phase_next   = efp_pkg::PH_RIGHT;
          overflow_seen_next = 1'b0;
          num_phase_next     = efp_pkg::NUM_SKIP;
          negative_sign_next = 1'b0;
          accumulator_next   = '0;
        end
      end
      efp_pkg::PH_RIGHT: begin
        if (s1_byte == efp_pkg::CH_COMMA) begin
          held_right_next    = cur_value;
          frame_phase_next   = efp_pkg::PH_LEFT;
          num_phase_next     = efp_pkg::NUM_SKIP;
          negative_sign_next = 1'b0;
          accumulator_next   = '0;
        end else begin
          feed = 1'b1;
        end
      end
      efp_pkg::PH_LEFT: begin
        if (s1_byte == efp_pkg::CH_COLON) begin
          held_left_next     = cur_value;
          frame_phase_next   = efp_pkg::PH_TIME;
          num_phase_next     = efp_pkg::NUM_SKIP;
          negative_sign_next = 1'b0;
          accumulator_next   = '0;
        end else begin
          feed = 1'b1;
        end
      end
      efp_pkg::PH_TIME: begin
        if (s1_byte == efp_pkg::CH_SEMI) begin
          emit               = 1'b1;
          latest_left_next   = held_left;
          latest_right_next  = held_right;
          latest_time_next   = cur_value;
          frame_phase_next   = efp_pkg::PH_HUNT;
          num_phase_next     = efp_pkg::NUM_SKIP;
          negative_sign_next = 1'b0;
          accumulator_next   = '0;
        end else begin
          feed = 1'b1;
        end
      end
      default: frame_phase_next = efp_pkg::PH_HUNT;
    endcase

    if (feed) begin
      unique case (num_phase)
        efp_pkg::NUM_SKIP: begin
          if (is_space) begin
            num_phase_next = efp_pkg::NUM_SKIP;
          end else if (s1_byte == efp_pkg::CH_PLUS || s1_byte == efp_pkg::CH_MINUS) begin
            negative_sign_next = (s1_byte == efp_pkg::CH_MINUS);
            num_phase_next     = efp_pkg::NUM_DIGITS;
          end else if (is_digit) begin
            num_phase_next = efp_pkg::NUM_DIGITS;
            take_digit     = 1'b1;
          end else begin
            num_phase_next = efp_pkg::NUM_DONE;
          end
        end
        efp_pkg::NUM_DIGITS: begin
          if (is_digit) begin
            take_digit = 1'b1;
          end else begin
            num_phase_next = efp_pkg::NUM_DONE;
          end
        end
        efp_pkg::NUM_DONE: num_phase_next = efp_pkg::NUM_DONE;
        default: num_phase_next = efp_pkg::NUM_DONE;
      endcase
    end

    if (take_digit) begin
      accumulator_next = step_acc;
      if (step_ovf) begin
        overflow_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase   <= efp_pkg::PH_HUNT;
      num_phase     <= efp_pkg::NUM_SKIP;
      negative_sign <= 1'b0;
      accumulator   <= '0;
      held_right    <= '0;
      held_left     <= '0;
      overflow_seen <= 1'b0;
      latest_left   <= '0;
      latest_right  <= '0;
      latest_time   <= '0;
    end else if (advance) begin
      frame_phase   <= frame_phase_next;
      num_phase     <= num_phase_next;
      negative_sign <= negative_sign_next;
      accumulator   <= accumulator_next;
      held_right    <= held_right_next;
      held_left     <= held_left_next;
      overflow_seen <= overflow_seen_next;
      latest_left   <= latest_left_next;
      latest_right  <= latest_right_next;
      latest_time   <= latest_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance && emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (advance && emit) begin
      res.left_ticks        <= efp_pkg::to_field(held_left);
      res.right_ticks       <= efp_pkg::to_field(held_right);
      res.elapsed_time      <= efp_pkg::to_field(cur_value);
      res.prev_left_ticks   <= efp_pkg::to_field(latest_left);
      res.prev_right_ticks  <= efp_pkg::to_field(latest_right);
      res.prev_elapsed_time <= efp_pkg::to_field(latest_time);
      res.saturated         <= overflow_seen;
    end
  end

endmodule

### sv/efp_digit_step.sv
// One decimal digit step of the field conversion: acc*10 + digit, clamped to
// the signed range of the field. Depends on efp_pkg.
module efp_digit_step (
  input  efp_pkg::value_t acc,
  input  logic            negative,
  input  logic [3:0]      digit,
  output efp_pkg::value_t acc_next,
  output logic            overflow
);

  localparam int W = efp_pkg::VALUE_WIDTH;

  logic [W-1:0] half;
  logic [W-1:0] limit;
  logic [W+3:0] times10;
  logic [W+3:0] sum;

  // The magnitude never exceeds 2^(W-1), so four extra bits hold acc*10+9.
  always_comb begin
    half     = W'(1) << (W - 1);
    limit    = negative ? half : half - W'(1);
    times10  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
    sum      = times10 + (W + 4)'(digit);
    overflow = sum > {4'b0000, limit};
    acc_next = overflow ? limit : sum[W-1:0];
  end

endmodule

### sv/efp_checker.sv
// Port-level checks for the encoder frame parser result channel, bound to
// the top level. Depends on efp_pkg and encoder_frame_parser_top.
module efp_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  res_valid,
  input logic                                  res_ready,
  input logic signed [efp_pkg::OUT_WIDTH-1:0] res_left_ticks,
  input logic signed [efp_pkg::OUT_WIDTH-1:0] res_right_ticks,
  input logic signed [efp_pkg::OUT_WIDTH-1:0] res_elapsed_time,
  input logic                                  res_saturated
);

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result withdrawn while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_left_ticks) && $stable(res_right_ticks)
      && $stable(res_elapsed_time) && $stable(res_saturated))
    else $error("result changed while stalled");

endmodule

bind encoder_frame_parser_top efp_checker u_efp_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_left_ticks   (res.left_ticks),
  .res_right_ticks  (res.right_ticks),
  .res_elapsed_time (res.elapsed_time),
  .res_saturated    (res.saturated)
);
